// ===== rtl/swp_pkg.sv =====
// Shared types, widths and register codes for the 3D acoustic stencil block.
// No dependencies; swp_window, swp_datapath and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package swp_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int VEL_W      = 16;
    localparam int COEF_W     = 16;
    localparam int TAPS_W     = 64;
    localparam int CFG_W      = 64;
    localparam int CFG_AW     = 3;
    localparam int NUM_AXES   = 3;
    localparam int HALF_SPAN  = 4;
    localparam int MIN_SIZE   = 9;
    localparam int SZ_XY_W    = 8;
    localparam int SZ_Z_W     = 16;

    // Datapath widths, all exact for full-range inputs
    localparam int PAIR_W     = SAMPLE_W + 1;
    localparam int PROD_W     = PAIR_W + COEF_W;
    localparam int PART_W     = PROD_W + 2;
    localparam int ACC_W      = PART_W + 2;
    localparam int RND1_SHIFT = 10;
    localparam int RND1_W     = ACC_W - RND1_SHIFT;
    localparam int LO_SPLIT   = 22;
    localparam int LO_W       = LO_SPLIT + VEL_W;
    localparam int HI_W       = RND1_W - LO_SPLIT + VEL_W + 1;
    localparam int MIX_W      = HI_W + LO_SPLIT;
    localparam int RND2_SHIFT = 14;
    localparam int RND2_W     = MIX_W - RND2_SHIFT;
    localparam int DP_W       = SAMPLE_W + 2;
    localparam int RES_W      = RND2_W + 1;

    typedef enum logic [CFG_AW-1:0] {
        REG_SIZE_X       = 3'd0,
        REG_SIZE_Y       = 3'd1,
        REG_SIZE_Z       = 3'd2,
        REG_COEFF_CENTER = 3'd3,
        REG_COEFF_X      = 3'd4,
        REG_COEFF_Y      = 3'd5,
        REG_COEFF_Z      = 3'd6
    } swp_reg_t;

    // Neighbour samples: [axis][distance-1], one side of the centre
    typedef logic [NUM_AXES-1:0][HALF_SPAN-1:0][SAMPLE_W-1:0] swp_taps_t;
    typedef logic [NUM_AXES-1:0][TAPS_W-1:0] swp_coefs_t;

    // Per-centre control travelling beside the arithmetic
    typedef struct packed {
        logic                      inner;
        logic                      last;
        logic signed [SAMPLE_W-1:0] p0;
        logic [VEL_W-1:0]          vel;
        logic signed [DP_W-1:0]    dp;
    } swp_side_t;

endpackage

`default_nettype wire

// ===== rtl/swp_tap_ram.sv =====
// Simple dual-port memory with registered read data, one window copy.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swp_tap_ram #(
    parameter int AW = 18,
    parameter int DW = 32
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/swp_window.sv =====
// Sample history and neighbour fetch: one memory copy per stencil tap, except the far z neighbour on the near side.
// Depends on swp_pkg and swp_tap_ram.
`timescale 1ns / 1ps
`default_nettype none

module swp_window
    import swp_pkg::*;
#(
    parameter int AW  = 18,
    parameter int NXW = 8,
    parameter int NYW = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                wr_en,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [NXW-1:0]      nx,
    input  wire logic [NYW-1:0]      ny,
    output swp_taps_t                taps_pos,
    output swp_taps_t                taps_neg,
    output logic      [SAMPLE_W-1:0] center
);

    logic [AW-1:0]       wp_reg, wp_next;
    logic [AW-1:0]       n12;
    logic [AW-1:0]       back_c;
    logic [AW-1:0]       stride [NUM_AXES];
    logic [SAMPLE_W-1:0] sample_reg;

    assign n12       = AW'(nx) * AW'(ny);
    assign back_c    = n12 * AW'(HALF_SPAN);
    assign stride[0] = AW'(1);
    assign stride[1] = AW'(nx);
    assign stride[2] = n12;
    assign wp_next   = wr_en ? wp_reg + AW'(1) : wp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else begin
            wp_reg <= wp_next;
        end
    end

    // The incoming sample is the far z neighbour on the near side
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_reg <= sample;
        end
    end

    swp_tap_ram #(.AW(AW), .DW(SAMPLE_W)) u_center (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wp_reg), .wr_data(sample),
        .rd_en(wr_en), .rd_addr(wp_reg - back_c), .rd_data(center)
    );

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        for (genvar k = 0; k < HALF_SPAN; k++) begin : g_dist
            logic [AW-1:0] back_pos, back_neg;
            assign back_pos = back_c + stride[a] * AW'(k + 1);
            assign back_neg = back_c - stride[a] * AW'(k + 1);

            swp_tap_ram #(.AW(AW), .DW(SAMPLE_W)) u_pos (
                .aclk(aclk), .wr_en(wr_en), .wr_addr(wp_reg), .wr_data(sample),
                .rd_en(wr_en), .rd_addr(wp_reg - back_pos),
                .rd_data(taps_pos[a][k])
            );

            if (a == NUM_AXES - 1 && k == HALF_SPAN - 1) begin : g_live
                assign taps_neg[a][k] = sample_reg;
            end else begin : g_mem
                swp_tap_ram #(.AW(AW), .DW(SAMPLE_W)) u_neg (
                    .aclk(aclk), .wr_en(wr_en), .wr_addr(wp_reg), .wr_data(sample),
                    .rd_en(wr_en), .rd_addr(wp_reg - back_neg),
                    .rd_data(taps_neg[a][k])
                );
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swp_datapath.sv =====
// Pipelined stencil arithmetic: pair sums, tap products, adder tree, rounding,
// split velocity multiply. Depends on swp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swp_datapath
    import swp_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_load,
    input  wire logic                      in_emit,
    input  swp_side_t                      in_side,
    input  swp_taps_t                      taps_pos,
    input  swp_taps_t                      taps_neg,
    input  wire logic [SAMPLE_W-1:0]       center,
    input  wire logic [COEF_W-1:0]         coeff_center,
    input  swp_coefs_t                     coeff_taps,
    output logic                           in_ready,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output swp_side_t                      out_side,
    output logic signed [RND2_W-1:0]       out_acc
);

    localparam int NST  = 7;
    localparam int NTAP = NUM_AXES * HALF_SPAN;

    logic [NST-1:0] vld_reg, vld_next, rdy;
    swp_side_t      side_reg [NST];

    logic signed [PAIR_W-1:0]   pair_reg [NTAP];
    logic signed [SAMPLE_W-1:0] cen_reg;
    logic signed [PROD_W-1:0]   prod_reg [NTAP + 1];
    logic signed [PART_W-1:0]   part_reg [NUM_AXES + 1];
    logic signed [RND1_W-1:0]   acc1_reg;
    logic        [LO_W-1:0]     lo_reg;
    logic signed [HI_W-1:0]     hi_reg;
    logic signed [RND2_W-1:0]   acc2_reg;

    logic signed [ACC_W-1:0]    total;
    logic signed [MIX_W-1:0]    mix;
    logic signed [PART_W-1:0]   psum [NUM_AXES];
    logic signed [DP_W-1:0]     dp;

    // A stage takes new contents when it is empty or its successor moves
    always_comb begin
        rdy[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next[0] = rdy[0] ? (in_load && in_emit) : vld_reg[0];
        for (int i = 1; i < NST; i++) begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            psum[a] = '0;
            for (int k = 0; k < HALF_SPAN; k++) begin
                psum[a] = psum[a] + PART_W'(prod_reg[a*HALF_SPAN + k]);
            end
        end
        total = ACC_W'(part_reg[0]) + ACC_W'(part_reg[1]) + ACC_W'(part_reg[2])
              + ACC_W'(part_reg[3]) + ACC_W'(signed'(1 << (RND1_SHIFT - 1)));
        mix = (MIX_W'(hi_reg) <<< LO_SPLIT) + $signed(MIX_W'(lo_reg))
            + MIX_W'(signed'(1 << (RND2_SHIFT - 1)));
        dp = (DP_W'($signed(center)) <<< 1) - DP_W'(side_reg[0].p0);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_load) begin
            side_reg[0] <= in_side;
        end
        if (rdy[1]) begin
            side_reg[1]    <= side_reg[0];
            side_reg[1].dp <= dp;
            cen_reg        <= $signed(center);
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < HALF_SPAN; k++) begin
                    pair_reg[a*HALF_SPAN + k] <= PAIR_W'($signed(taps_pos[a][k]))
                                               + PAIR_W'($signed(taps_neg[a][k]));
                end
            end
        end
        if (rdy[2]) begin
            side_reg[2] <= side_reg[1];
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < HALF_SPAN; k++) begin
                    prod_reg[a*HALF_SPAN + k] <=
                        PROD_W'($signed(coeff_taps[a][COEF_W*k +: COEF_W]))
                        * PROD_W'(pair_reg[a*HALF_SPAN + k]);
                end
            end
            prod_reg[NTAP] <= PROD_W'($signed(coeff_center)) * PROD_W'(cen_reg);
        end
        if (rdy[3]) begin
            side_reg[3] <= side_reg[2];
            for (int a = 0; a < NUM_AXES; a++) begin
                part_reg[a] <= psum[a];
            end
            part_reg[NUM_AXES] <= PART_W'(prod_reg[NTAP]);
        end
        if (rdy[4]) begin
            side_reg[4] <= side_reg[3];
            acc1_reg    <= RND1_W'(total >>> RND1_SHIFT);
        end
        if (rdy[5]) begin
            side_reg[5] <= side_reg[4];
            lo_reg <= LO_W'(acc1_reg[LO_SPLIT-1:0]) * LO_W'(side_reg[4].vel);
            hi_reg <= HI_W'($signed(acc1_reg[RND1_W-1:LO_SPLIT]))
                    * HI_W'($signed({1'b0, side_reg[4].vel}));
        end
        if (rdy[6]) begin
            side_reg[6] <= side_reg[5];
            acc2_reg    <= RND2_W'(mix >>> RND2_SHIFT);
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    assign out_acc   = acc2_reg;

endmodule

`default_nettype wire

// ===== rtl/stencil_wave_propagation_3d.sv =====
// Top level of the 25-point, 8th-order 3D acoustic wave stencil engine.
// Depends on swp_pkg, swp_window, swp_datapath (and swp_tap_ram below it).
//
// Usage:
//   s_ channel: one current-field sample per transfer in raster order (x fastest),
//     with the previous-step value and velocity of the centre emitted for it.
//     s_tuser[0] marks voxel (0,0,0) of a new volume; the counters also wrap
//     on their own after the last voxel.
//   m_ channel: one result per sample once four planes are in; samples of the
//     first four planes of a volume give no result. tuser[0] is set when the
//     stencil was applied, tlast on the last interior centre of the volume.
//   Configuration: cfg_wr_en/cfg_addr/cfg_wdata write one register per edge,
//     no read-back; write only while no result is outstanding.
// Throughput: one transfer per cycle on each side, sustained while m_tready stays high.
// Pipeline: after its sample is accepted, a result passes one memory read, six
//   arithmetic stages, then the output register.
// Reset: counters and pipeline valid bits clear, sizes return to 128, all
//   coefficients to zero. The sample history is not cleared.
// Stall: when m_tready is low the result holds in the output register; the
//   pipeline keeps accepting until its bubbles are used up, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module stencil_wave_propagation_3d
    import swp_pkg::*;
#(
    parameter int MAX_ROW        = 128,
    parameter int MAX_PLANE_ROWS = 128
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // [31:0] field_sample, [63:32] prior_center, [79:64] velocity_center
    input  wire logic [79:0]       s_tdata,
    // [0] volume_start
    input  wire logic [0:0]        s_tuser,
    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // [31:0] next_value
    output logic [31:0]           m_tdata,
    // [0] interior
    output logic [0:0]            m_tuser,
    output logic                  m_tlast,
    // Configuration writes
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int XCW    = $clog2(MAX_ROW);
    localparam int YCW    = $clog2(MAX_PLANE_ROWS);
    localparam int NXW    = $clog2(MAX_ROW + 1);
    localparam int NYW    = $clog2(MAX_PLANE_ROWS + 1);
    localparam int XPW    = NXW + 1;
    localparam int YPW    = NYW + 1;
    localparam int ZPW    = SZ_Z_W + 1;
    localparam int WIN_AW = $clog2(2 * HALF_SPAN * MAX_ROW * MAX_PLANE_ROWS + 1);

    localparam logic signed [RES_W-1:0] SAT_MAX = RES_W'(signed'(32'h7FFF_FFFF));
    localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

    // Configuration registers
    logic [SZ_XY_W-1:0] size_x_reg, size_y_reg;
    logic [SZ_Z_W-1:0]  size_z_reg;
    logic [COEF_W-1:0]  coeff_center_reg;
    swp_coefs_t         coeff_taps_reg;

    // Raster position of the next sample
    logic [XCW-1:0]    in_x_reg, in_x_next;
    logic [YCW-1:0]    in_y_reg, in_y_next;
    logic [SZ_Z_W-1:0] in_z_reg, in_z_next;

    logic [NXW-1:0]    nx;
    logic [NYW-1:0]    ny;
    logic [SZ_Z_W-1:0] nz;
    logic [31:0]       sx_wide, sy_wide;

    logic [XCW-1:0]    cx;
    logic [YCW-1:0]    cy;
    logic [SZ_Z_W-1:0] cz;
    logic [XPW-1:0]    cx_w;
    logic [YPW-1:0]    cy_w;
    logic [ZPW-1:0]    cz_w;
    logic              emit, inner, last;
    logic              accept;
    swp_side_t         side_in;

    swp_taps_t           taps_pos, taps_neg;
    logic [SAMPLE_W-1:0] center;
    logic                dp_valid;
    swp_side_t           dp_side;
    logic signed [RND2_W-1:0] dp_acc;

    // Output register
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_inner_reg, m_last_reg;
    logic              out_adv;
    logic signed [RES_W-1:0] res_wide;
    logic [31:0]       res_sat;

    assign accept = s_tvalid && s_tready;

    // ---- configuration ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg       <= SZ_XY_W'(128);
            size_y_reg       <= SZ_XY_W'(128);
            size_z_reg       <= SZ_Z_W'(128);
            coeff_center_reg <= '0;
            coeff_taps_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SIZE_X:       size_x_reg       <= cfg_wdata[SZ_XY_W-1:0];
                REG_SIZE_Y:       size_y_reg       <= cfg_wdata[SZ_XY_W-1:0];
                REG_SIZE_Z:       size_z_reg       <= cfg_wdata[SZ_Z_W-1:0];
                REG_COEFF_CENTER: coeff_center_reg <= cfg_wdata[COEF_W-1:0];
                REG_COEFF_X:      coeff_taps_reg[0] <= cfg_wdata;
                REG_COEFF_Y:      coeff_taps_reg[1] <= cfg_wdata;
                REG_COEFF_Z:      coeff_taps_reg[2] <= cfg_wdata;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // Clamp x and y sizes between MIN_SIZE and what the window can hold; z only from below
    always_comb begin
        sx_wide = 32'(size_x_reg);
        sy_wide = 32'(size_y_reg);
        if (sx_wide < 32'(MIN_SIZE)) begin
            sx_wide = 32'(MIN_SIZE);
        end else if (sx_wide > 32'(MAX_ROW)) begin
            sx_wide = 32'(MAX_ROW);
        end
        if (sy_wide < 32'(MIN_SIZE)) begin
            sy_wide = 32'(MIN_SIZE);
        end else if (sy_wide > 32'(MAX_PLANE_ROWS)) begin
            sy_wide = 32'(MAX_PLANE_ROWS);
        end
        nx = NXW'(sx_wide);
        ny = NYW'(sy_wide);
        nz = (size_z_reg < SZ_Z_W'(MIN_SIZE)) ? SZ_Z_W'(MIN_SIZE) : size_z_reg;
    end

    // ---- raster counters and centre classification ----
    // The centre of this transfer sits at (x, y, z - HALF_SPAN).
    always_comb begin
        cx   = s_tuser[0] ? '0 : in_x_reg;
        cy   = s_tuser[0] ? '0 : in_y_reg;
        cz   = s_tuser[0] ? '0 : in_z_reg;
        cx_w = XPW'(cx);
        cy_w = YPW'(cy);
        cz_w = ZPW'(cz);

        emit  = cz_w >= ZPW'(HALF_SPAN);
        inner = emit
             && cx_w >= XPW'(HALF_SPAN) && cx_w + XPW'(HALF_SPAN) < XPW'(nx)
             && cy_w >= YPW'(HALF_SPAN) && cy_w + YPW'(HALF_SPAN) < YPW'(ny)
             && cz_w >= ZPW'(2 * HALF_SPAN) && cz_w < ZPW'(nz);
        last  = inner
             && cx_w + XPW'(HALF_SPAN + 1) == XPW'(nx)
             && cy_w + YPW'(HALF_SPAN + 1) == YPW'(ny)
             && cz_w + ZPW'(1) == ZPW'(nz);

        // Advance x, carry into y and z; wrap at the volume end
        in_x_next = in_x_reg;
        in_y_next = in_y_reg;
        in_z_next = in_z_reg;
        if (accept) begin
            in_x_next = XCW'(cx_w + XPW'(1));
            in_y_next = cy;
            in_z_next = cz;
            if (cx_w + XPW'(1) >= XPW'(nx)) begin
                in_x_next = '0;
                in_y_next = YCW'(cy_w + YPW'(1));
                if (cy_w + YPW'(1) >= YPW'(ny)) begin
                    in_y_next = '0;
                    in_z_next = SZ_Z_W'(cz_w + ZPW'(1));
                    if (cz_w + ZPW'(1) >= ZPW'(nz)) begin
                        in_z_next = '0;
                    end
                end
            end
        end

        side_in.inner = inner;
        side_in.last  = last;
        side_in.p0    = $signed(s_tdata[63:32]);
        side_in.vel   = s_tdata[79:64];
        side_in.dp    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_x_reg <= '0;
            in_y_reg <= '0;
            in_z_reg <= '0;
        end else begin
            in_x_reg <= in_x_next;
            in_y_reg <= in_y_next;
            in_z_reg <= in_z_next;
        end
    end

    // ---- sample history, one read per tap except the far z neighbour ----
    swp_window #(.AW(WIN_AW), .NXW(NXW), .NYW(NYW)) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (accept),
        .sample   (s_tdata[31:0]),
        .nx       (nx),
        .ny       (ny),
        .taps_pos (taps_pos),
        .taps_neg (taps_neg),
        .center   (center)
    );

    // ---- arithmetic pipeline ----
    swp_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_load      (accept),
        .in_emit      (emit),
        .in_side      (side_in),
        .taps_pos     (taps_pos),
        .taps_neg     (taps_neg),
        .center       (center),
        .coeff_center (coeff_center_reg),
        .coeff_taps   (coeff_taps_reg),
        .in_ready     (s_tready),
        .out_ready    (out_adv),
        .out_valid    (dp_valid),
        .out_side     (dp_side),
        .out_acc      (dp_acc)
    );

    // ---- final add, saturation and output register ----
    assign out_adv  = !m_valid_reg || m_tready;
    assign res_wide = RES_W'(dp_acc) + RES_W'(dp_side.dp);

    always_comb begin
        if (res_wide > SAT_MAX) begin
            res_sat = 32'h7FFF_FFFF;
        end else if (res_wide < SAT_MIN) begin
            res_sat = 32'h8000_0000;
        end else begin
            res_sat = res_wide[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= dp_valid;
        end
    end

    // Boundary centres pass the prior value through
    always_ff @(posedge aclk) begin
        if (out_adv && dp_valid) begin
            m_data_reg  <= dp_side.inner ? res_sat : dp_side.p0;
            m_inner_reg <= dp_side.inner;
            m_last_reg  <= dp_side.last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_inner_reg;
    assign m_tlast    = m_last_reg;

    // ---- assertions ----
    a_last_is_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("volume end flagged on a boundary centre");

    a_volume_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0]
        |=> in_x_reg == XCW'(1) && in_y_reg == '0 && in_z_reg == '0)
        else $error("raster counters did not restart on volume start");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

endmodule

`default_nettype wire
